[rtl/core/lcnc_pkg.sv]
`timescale 1ns / 1ps

package lcnc_pkg;

   // Binary side of the converter and the decimal digits it can produce
   localparam int BIN_BITS    = 63;
   localparam int BCD_DIGITS  = 19;
   localparam int BCD_BITS    = 4 * BCD_DIGITS;
   localparam int DD_WORD     = BCD_BITS + BIN_BITS;

   // Shift steps folded into one register stage of the converter
   localparam int DD_STEPS    = 8;
   localparam int DD_STAGES   = (BIN_BITS + DD_STEPS - 1) / DD_STEPS;

   // Digit sum grouping: four digits per group, each group at most 36
   localparam int GRP_DIGITS  = 4;
   localparam int GRP_BITS    = 6;
   localparam int SUM_BITS    = 8;
   localparam int COUNT_BITS  = 5;

   // Stages after the converter: digit scan, then sum and classify
   localparam int POST_STAGES = 2;

   localparam logic [COUNT_BITS-1:0] LEN_13 = 5'd13;
   localparam logic [COUNT_BITS-1:0] LEN_15 = 5'd15;
   localparam logic [COUNT_BITS-1:0] LEN_16 = 5'd16;

   typedef logic [DD_WORD-1:0] dd_word_type;
   typedef logic [3:0]         digit_type;

   typedef enum logic [1:0] {
      KIND_INVALID = 2'd0,
      KIND_LEAD4   = 2'd1,
      KIND_LEAD5X  = 2'd2,
      KIND_LEAD3X  = 2'd3
   } card_kind_type;

   // One double-dabble step: correct each digit that is 5 or more, then shift
   function automatic dd_word_type dd_step(input dd_word_type w);
      dd_word_type t;
      digit_type   d;
      t = w;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         d = t[BIN_BITS + 4*i +: 4];
         if (d >= 4'd5) begin
            t[BIN_BITS + 4*i +: 4] = d + 4'd3;
         end
      end
      return {t[DD_WORD-2:0], 1'b0};
   endfunction

   // Doubled digit with nine taken off when it runs past nine
   function automatic digit_type luhn_double(input digit_type d);
      digit_type r;
      case (d)
         4'd0:    r = 4'd0;
         4'd1:    r = 4'd2;
         4'd2:    r = 4'd4;
         4'd3:    r = 4'd6;
         4'd4:    r = 4'd8;
         4'd5:    r = 4'd1;
         4'd6:    r = 4'd3;
         4'd7:    r = 4'd5;
         4'd8:    r = 4'd7;
         4'd9:    r = 4'd9;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   // Digit sum never exceeds 171, so compare against each multiple of ten
   function automatic logic is_mult10(input logic [SUM_BITS-1:0] s);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k <= 17; k++) begin
         if (s == SUM_BITS'(10 * k)) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

[rtl/core/lcnc_bcd_pipe.sv]
`timescale 1ns / 1ps

module lcnc_bcd_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [lcnc_pkg::BIN_BITS-1:0] in_number,
   output logic                          out_valid,
   output logic [lcnc_pkg::BCD_BITS-1:0] out_bcd
);

   localparam int NS = lcnc_pkg::DD_STAGES;

   lcnc_pkg::dd_word_type sr_src [NS];
   lcnc_pkg::dd_word_type sr_in  [NS];
   lcnc_pkg::dd_word_type sr_ff  [NS];
   logic                  valid_ff [NS];

   assign sr_src[0] = {{lcnc_pkg::BCD_BITS{1'b0}}, in_number};

   for (genvar k = 1; k < NS; k++) begin : g_link
      assign sr_src[k] = sr_ff[k-1];
   end

   for (genvar k = 0; k < NS; k++) begin : g_stage
      always_comb begin
         lcnc_pkg::dd_word_type w;
         w = sr_src[k];
         // the last stage runs only the steps left over
         for (int j = 0; j < lcnc_pkg::DD_STEPS; j++) begin
            if (k * lcnc_pkg::DD_STEPS + j < lcnc_pkg::BIN_BITS) begin
               w = lcnc_pkg::dd_step(w);
            end
         end
         sr_in[k] = w;
      end

      always_ff @(posedge clock) begin
         sr_ff[k] <= sr_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_bcd   = sr_ff[NS-1][lcnc_pkg::DD_WORD-1 -: lcnc_pkg::BCD_BITS];

endmodule

[rtl/core/luhn_card_number_classifier.sv]
`timescale 1ns / 1ps

// Card number classifier. A number beat is taken on any cycle where start is
// high and busy is low; busy is high only during reset, so one number can
// enter every cycle. Each beat gives exactly one result, a rsp_valid pulse
// of one cycle, once the number has passed the 8 binary-to-decimal converter
// stages of 8 shift steps each except the last, which runs the remaining 7,
// one digit scan stage and one sum and classify stage. Results leave in the
// order the numbers came in and the receiver must take them as they come.
// Only the lowest MAX_DIGITS decimal digits are checked.
module luhn_card_number_classifier #(
   parameter int MAX_DIGITS = 19
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [62:0] req_card_number,
   output logic        rsp_valid,
   output logic [1:0]  rsp_card_kind,
   output logic        rsp_luhn_ok,
   output logic [4:0]  rsp_digit_count
);

   localparam int NG  = (MAX_DIGITS + lcnc_pkg::GRP_DIGITS - 1) / lcnc_pkg::GRP_DIGITS;
   localparam int LAT = lcnc_pkg::DD_STAGES + lcnc_pkg::POST_STAGES;

   logic                          take;
   logic                          bcd_valid;
   logic [lcnc_pkg::BCD_BITS-1:0] bcd;

   assign busy = reset;
   assign take = start & ~busy;

   lcnc_bcd_pipe u_bcd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (take),
      .in_number (req_card_number),
      .out_valid (bcd_valid),
      .out_bcd   (bcd)
   );

   // Scan stage: group digit sums, digit count and the two leading digits
   logic [lcnc_pkg::GRP_BITS-1:0]   grp_in [NG];
   logic [lcnc_pkg::GRP_BITS-1:0]   grp_ff [NG];
   logic [lcnc_pkg::COUNT_BITS-1:0] count_in, count_ff;
   lcnc_pkg::digit_type             lead1_in, lead1_ff;
   lcnc_pkg::digit_type             lead2_in, lead2_ff;
   logic                            scan_valid_ff;

   always_comb begin
      lcnc_pkg::digit_type d;
      lcnc_pkg::digit_type v;
      lcnc_pkg::digit_type below;
      for (int g = 0; g < NG; g++) begin
         grp_in[g] = '0;
      end
      count_in = '0;
      lead1_in = '0;
      lead2_in = '0;
      below    = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         d = bcd[4*i +: 4];
         v = i[0] ? lcnc_pkg::luhn_double(d) : d;
         grp_in[i >> 2] = grp_in[i >> 2] + lcnc_pkg::GRP_BITS'(v);
         if (d != 4'd0) begin
            count_in = lcnc_pkg::COUNT_BITS'(i + 1);
            lead1_in = d;
            lead2_in = below;
         end
         below = d;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff   <= grp_in;
      count_ff <= count_in;
      lead1_ff <= lead1_in;
      lead2_ff <= lead2_in;
   end

   // Sum and classify stage, straight into the result registers
   logic [lcnc_pkg::SUM_BITS-1:0]   sum;
   logic                            ok_in, ok_ff;
   lcnc_pkg::card_kind_type         kind_in, kind_ff;
   logic                            rsp_valid_ff;

   always_comb begin
      sum = '0;
      for (int g = 0; g < NG; g++) begin
         sum = sum + lcnc_pkg::SUM_BITS'(grp_ff[g]);
      end
      ok_in   = lcnc_pkg::is_mult10(sum);
      kind_in = lcnc_pkg::KIND_INVALID;
      if (ok_in && count_ff != '0) begin
         if ((count_ff == lcnc_pkg::LEN_13 || count_ff == lcnc_pkg::LEN_16)
             && lead1_ff == 4'd4) begin
            kind_in = lcnc_pkg::KIND_LEAD4;
         end else if (count_ff == lcnc_pkg::LEN_16 && lead1_ff == 4'd5
                      && lead2_ff >= 4'd1 && lead2_ff <= 4'd5) begin
            kind_in = lcnc_pkg::KIND_LEAD5X;
         end else if (count_ff == lcnc_pkg::LEN_15 && lead1_ff == 4'd3
                      && (lead2_ff == 4'd4 || lead2_ff == 4'd7)) begin
            kind_in = lcnc_pkg::KIND_LEAD3X;
         end
      end
   end

   logic [lcnc_pkg::COUNT_BITS-1:0] out_count_ff;

   always_ff @(posedge clock) begin
      ok_ff        <= ok_in;
      kind_ff      <= kind_in;
      out_count_ff <= count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         scan_valid_ff <= bcd_valid;
         rsp_valid_ff  <= scan_valid_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_card_kind   = kind_ff;
   assign rsp_luhn_ok     = ok_ff;
   assign rsp_digit_count = out_count_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      take |-> ##LAT rsp_valid)
      else $error("taken beat did not produce a result on time");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit_count <= 5'(MAX_DIGITS))
      else $error("digit count beyond digit positions");

   a_kind_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_card_kind != lcnc_pkg::KIND_INVALID |-> rsp_luhn_ok)
      else $error("valid kind on a failed check");

   a_lead4_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_card_kind == lcnc_pkg::KIND_LEAD4
      |-> rsp_digit_count == lcnc_pkg::LEN_13 || rsp_digit_count == lcnc_pkg::LEN_16)
      else $error("lead four kind with wrong length");

endmodule
